>>> hdl/assert_macros.svh
// Assertion helpers: clocked on clk, quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property.
`define SCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert that an expression never holds.
`define SCC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> hdl/scc_pkg.sv
`default_nettype none
package scc_pkg;

  localparam int unsigned Q_ONE  = 65536;
  localparam int unsigned T_HIGH = 65537;

  localparam int ISQ_STEPS = 64;
  localparam int DIV_STEPS = 18;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int FRONT_LAT = 7;
  localparam int TOTAL_LAT = FRONT_LAT + ISQ_STEPS + 1 + DIV_LAT + 1;

  typedef logic signed [17:0] tq_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] sphere_radius;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;
    logic signed [31:0] cyl_radius;
    logic signed [31:0] cyl_height;
  } scc_in_t;

  typedef struct packed {
    logic        hit;
    logic [16:0] entry_time;
  } scc_out_t;

  typedef struct packed {
    logic               lim;
    logic               miss;
    logic signed [35:0] lo_n;
    logic signed [35:0] up_n;
    logic [32:0]        den;
  } vert_t;

  typedef struct packed {
    logic [63:0] a;
    logic        bneg;
    logic [63:0] bmag;
    logic        lim;
    logic        miss;
  } horz_t;

  typedef struct packed {
    horz_t h;
    vert_t v;
  } side_t;

  typedef struct packed {
    logic hlim;
    logic hmiss;
    logic vlim;
    logic vmiss;
  } flag_t;

endpackage
`default_nettype wire

>>> hdl/segment_cylinder_contact.sv
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the 64-stage square root and the 20-stage time dividers.
// Reset (rst_n low, synchronous) clears every valid bit; data registers keep
// their contents and are ignored until a valid item reaches them.
`default_nettype none
`include "assert_macros.svh"
module segment_cylinder_contact (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire scc_pkg::scc_in_t in_item,
  output logic                  out_valid,
  output scc_pkg::scc_out_t     out_item
);

  // Every item is taken: the pipeline has no back pressure.
  assign busy = 1'b0;

  // Front end: differences, coefficients a, b, c and the discriminant.
  logic           fr_vld;
  logic [127:0]   fr_disc;
  scc_pkg::side_t fr_side;

  scc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .in_item (in_item),
    .out_vld (fr_vld),
    .disc    (fr_disc),
    .side    (fr_side)
  );

  // Square root of the discriminant, one bit per stage.
  logic        sq_vld;
  logic [63:0] sq_root;

  scc_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (fr_vld),
    .rad     (fr_disc),
    .out_vld (sq_vld),
    .root    (sq_root)
  );

  // Hold the rest of the item alongside the root.
  scc_pkg::side_t side_d_r [0:scc_pkg::ISQ_STEPS-1];

  always_ff @(posedge clk) begin
    side_d_r[0] <= fr_side;
    for (int i = 1; i < scc_pkg::ISQ_STEPS; i++) begin
      side_d_r[i] <= side_d_r[i-1];
    end
  end

  // Numerators of the two horizontal roots: -b - root and -b + root.
  scc_pkg::side_t     sq_side;
  logic signed [66:0] nb_nxt, en_nxt, ln_nxt;
  logic signed [35:0] lo_abs_nxt, up_abs_nxt;

  assign sq_side = side_d_r[scc_pkg::ISQ_STEPS-1];

  always_comb begin
    nb_nxt = sq_side.h.bneg ? $signed({3'b000, sq_side.h.bmag})
                            : -$signed({3'b000, sq_side.h.bmag});
    en_nxt = nb_nxt - $signed({3'b000, sq_root});
    ln_nxt = nb_nxt + $signed({3'b000, sq_root});
    lo_abs_nxt = sq_side.v.lo_n[35] ? -sq_side.v.lo_n : sq_side.v.lo_n;
    up_abs_nxt = sq_side.v.up_n[35] ? -sq_side.v.up_n : sq_side.v.up_n;
  end

  logic          e_vld_r;
  logic          en_neg_r, ln_neg_r, lo_neg_r, up_neg_r;
  logic [65:0]   en_mag_r, ln_mag_r, lo_mag_r, up_mag_r;
  logic [63:0]   hden_r, vden_r;
  scc_pkg::flag_t e_flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    en_neg_r <= en_nxt[66];
    en_mag_r <= en_nxt[66] ? 66'(-en_nxt) : en_nxt[65:0];
    ln_neg_r <= ln_nxt[66];
    ln_mag_r <= ln_nxt[66] ? 66'(-ln_nxt) : ln_nxt[65:0];
    lo_neg_r <= sq_side.v.lo_n[35];
    lo_mag_r <= {30'd0, lo_abs_nxt[35:0]};
    up_neg_r <= sq_side.v.up_n[35];
    up_mag_r <= {30'd0, up_abs_nxt[35:0]};
    hden_r   <= sq_side.h.a;
    vden_r   <= {31'd0, sq_side.v.den};
    e_flag_r <= '{hlim: sq_side.h.lim, hmiss: sq_side.h.miss,
                  vlim: sq_side.v.lim, vmiss: sq_side.v.miss};
  end

  // Four time dividers in parallel.
  logic         te_vld, tl_vld, tv0_vld, tv1_vld;
  scc_pkg::tq_t te_q, tl_q, tv0_q, tv1_q;

  scc_qdiv u_div_hent (
    .clk (clk), .rst_n (rst_n), .in_vld (e_vld_r),
    .num_neg (en_neg_r), .num_mag (en_mag_r), .den (hden_r),
    .out_vld (te_vld), .tq (te_q)
  );

  scc_qdiv u_div_hlev (
    .clk (clk), .rst_n (rst_n), .in_vld (e_vld_r),
    .num_neg (ln_neg_r), .num_mag (ln_mag_r), .den (hden_r),
    .out_vld (tl_vld), .tq (tl_q)
  );

  scc_qdiv u_div_vlo (
    .clk (clk), .rst_n (rst_n), .in_vld (e_vld_r),
    .num_neg (lo_neg_r), .num_mag (lo_mag_r), .den (vden_r),
    .out_vld (tv0_vld), .tq (tv0_q)
  );

  scc_qdiv u_div_vup (
    .clk (clk), .rst_n (rst_n), .in_vld (e_vld_r),
    .num_neg (up_neg_r), .num_mag (up_mag_r), .den (vden_r),
    .out_vld (tv1_vld), .tq (tv1_q)
  );

  // Hold the miss and limit flags alongside the dividers.
  scc_pkg::flag_t flag_d_r [0:scc_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    flag_d_r[0] <= e_flag_r;
    for (int i = 1; i < scc_pkg::DIV_LAT; i++) begin
      flag_d_r[i] <= flag_d_r[i-1];
    end
  end

  // Merge the intervals: enter is the latest lower bound, leave the earliest
  // upper bound, both clipped to 0..1.
  scc_pkg::flag_t    fl;
  scc_pkg::tq_t      enter_nxt, leave_nxt, tmin_nxt, tmax_nxt;
  logic              miss_nxt, hit_nxt, fin_vld;
  scc_pkg::scc_out_t out_nxt;

  assign fl      = flag_d_r[scc_pkg::DIV_LAT-1];
  assign fin_vld = te_vld && tl_vld && tv0_vld && tv1_vld;

  always_comb begin
    enter_nxt = '0;
    leave_nxt = 18'(scc_pkg::Q_ONE);
    tmin_nxt  = (tv0_q < tv1_q) ? tv0_q : tv1_q;
    tmax_nxt  = (tv0_q < tv1_q) ? tv1_q : tv0_q;
    if (fl.hlim && !fl.hmiss) begin
      if (te_q > enter_nxt) enter_nxt = te_q;
      if (tl_q < leave_nxt) leave_nxt = tl_q;
    end
    if (fl.vlim) begin
      if (tmin_nxt > enter_nxt) enter_nxt = tmin_nxt;
      if (tmax_nxt < leave_nxt) leave_nxt = tmax_nxt;
    end
    miss_nxt = fl.hmiss || fl.vmiss;
    hit_nxt  = !miss_nxt && (enter_nxt <= leave_nxt);
    out_nxt.hit        = hit_nxt;
    out_nxt.entry_time = hit_nxt ? enter_nxt[16:0] : 17'd0;
  end

  logic              out_valid_r;
  scc_pkg::scc_out_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `SCC_ASSERT(a_lat_in, start |-> ##(scc_pkg::TOTAL_LAT) out_valid, "item lost in pipeline")
  `SCC_ASSERT(a_lat_none, !start |-> ##(scc_pkg::TOTAL_LAT) !out_valid, "item invented")
  `SCC_NEVER(a_miss_zero, out_valid && !out_item.hit && (|out_item.entry_time), "miss time set")
  `SCC_NEVER(a_time_rng, out_valid && (out_item.entry_time > 17'(scc_pkg::Q_ONE)), "time above one")

endmodule
`default_nettype wire

>>> hdl/scc_isqrt.sv
`default_nettype none
// Pipelined integer square root, one root bit per stage.
module scc_isqrt (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_vld,
  input  wire logic [127:0] rad,
  output logic              out_vld,
  output logic [63:0]       root
);

  logic         vld_r  [1:scc_pkg::ISQ_STEPS];
  logic [127:0] rem_r  [1:scc_pkg::ISQ_STEPS];
  logic [63:0]  root_r [1:scc_pkg::ISQ_STEPS];

  for (genvar i = 0; i < scc_pkg::ISQ_STEPS; i++) begin : g_step
    localparam int K = scc_pkg::ISQ_STEPS - 1 - i;
    logic         vld_cur;
    logic [127:0] rem_cur;
    logic [63:0]  root_cur;
    logic [128:0] trial;

    if (i == 0) begin : g_first
      assign vld_cur  = in_vld;
      assign rem_cur  = rad;
      assign root_cur = '0;
    end else begin : g_next
      assign vld_cur  = vld_r[i];
      assign rem_cur  = rem_r[i];
      assign root_cur = root_r[i];
    end

    // candidate^2 - root^2 = root*2^(k+1) + 2^(2k)
    assign trial = ({65'd0, root_cur} << (K + 1)) | (129'd1 << (2 * K));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_cur;
      end
    end

    always_ff @(posedge clk) begin
      if ({1'b0, rem_cur} >= trial) begin
        rem_r[i+1]  <= rem_cur - trial[127:0];
        root_r[i+1] <= root_cur | (64'd1 << K);
      end else begin
        rem_r[i+1]  <= rem_cur;
        root_r[i+1] <= root_cur;
      end
    end
  end

  assign out_vld = vld_r[scc_pkg::ISQ_STEPS];
  assign root    = root_r[scc_pkg::ISQ_STEPS];

endmodule
`default_nettype wire

>>> hdl/scc_qdiv.sv
`default_nettype none
// Pipelined time quantizer: floor(num * 2^16 / den), saturated to -1..65537.
module scc_qdiv (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_vld,
  input  wire logic        num_neg,
  input  wire logic [65:0] num_mag,
  input  wire logic [63:0] den,
  output logic             out_vld,
  output scc_pkg::tq_t     tq
);

  localparam int N = scc_pkg::DIV_STEPS;

  logic        vld_r  [0:N];
  logic        zero_r [0:N];
  logic        neg_r  [0:N];
  logic        sat_r  [0:N];
  logic [63:0] den_r  [0:N];
  logic [81:0] rem_r  [0:N];
  logic [17:0] q_r    [0:N];
  logic        ovld_r;
  scc_pkg::tq_t tq_r;

  // prep: flag zero, sign and quotients of 2^18 or more
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    zero_r[0] <= (num_mag == '0);
    neg_r[0]  <= num_neg;
    sat_r[0]  <= ({1'b0, num_mag} >= {1'b0, den, 2'b00});
    den_r[0]  <= den;
    rem_r[0]  <= {num_mag, 16'd0};
    q_r[0]    <= '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam int K = N - 1 - i;
    logic [81:0] trial;

    assign trial = {18'd0, den_r[i]} << K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      zero_r[i+1] <= zero_r[i];
      neg_r[i+1]  <= neg_r[i];
      sat_r[i+1]  <= sat_r[i];
      den_r[i+1]  <= den_r[i];
      if (rem_r[i] >= trial) begin
        rem_r[i+1] <= rem_r[i] - trial;
        q_r[i+1]   <= q_r[i] | (18'd1 << K);
      end else begin
        rem_r[i+1] <= rem_r[i];
        q_r[i+1]   <= q_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (zero_r[N]) begin
      tq_r <= '0;
    end else if (neg_r[N]) begin
      tq_r <= -18'sd1;
    end else if (sat_r[N] || (q_r[N] > 18'(scc_pkg::T_HIGH))) begin
      tq_r <= 18'(scc_pkg::T_HIGH);
    end else begin
      tq_r <= $signed(q_r[N]);
    end
  end

  assign out_vld = ovld_r;
  assign tq      = tq_r;

endmodule
`default_nettype wire

>>> hdl/scc_front.sv
`default_nettype none
// Front end: differences, prescale, products, coefficients and discriminant.
module scc_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire scc_pkg::scc_in_t in_item,
  output logic                  out_vld,
  output logic [127:0]          disc,
  output scc_pkg::side_t        side
);

  logic vld1_r, vld2_r, vld3_r, vld4_r, vld5_r, vld6_r, vld7_r;

  // stage 1
  logic signed [32:0] rx_nxt, rz_nxt, sx_nxt, sz_nxt, reach_nxt, ry_nxt, sy_nxt;
  logic               big_nxt;
  logic signed [31:0] rx1_r, rz1_r, sx1_r, sz1_r, reach1_r, sr1_r, ch1_r;
  logic signed [32:0] ry1_r, sy1_r;

  always_comb begin
    rx_nxt = {in_item.start_x[31], in_item.start_x} - {in_item.base_x[31], in_item.base_x};
    rz_nxt = {in_item.start_z[31], in_item.start_z} - {in_item.base_z[31], in_item.base_z};
    ry_nxt = {in_item.start_y[31], in_item.start_y} - {in_item.base_y[31], in_item.base_y};
    sx_nxt = {in_item.end_x[31], in_item.end_x} - {in_item.start_x[31], in_item.start_x};
    sz_nxt = {in_item.end_z[31], in_item.end_z} - {in_item.start_z[31], in_item.start_z};
    sy_nxt = {in_item.end_y[31], in_item.end_y} - {in_item.start_y[31], in_item.start_y};
    reach_nxt = (in_item.sphere_radius[31] ? 33'sd0 : {1'b0, in_item.sphere_radius})
              + (in_item.cyl_radius[31] ? 33'sd0 : {1'b0, in_item.cyl_radius});
    big_nxt = (rx_nxt[32] != rx_nxt[31]) || (rz_nxt[32] != rz_nxt[31])
           || (sx_nxt[32] != sx_nxt[31]) || (sz_nxt[32] != sz_nxt[31])
           || (reach_nxt[32] != reach_nxt[31]);
  end

  always_ff @(posedge clk) begin
    rx1_r    <= big_nxt ? rx_nxt[32:1] : rx_nxt[31:0];
    rz1_r    <= big_nxt ? rz_nxt[32:1] : rz_nxt[31:0];
    sx1_r    <= big_nxt ? sx_nxt[32:1] : sx_nxt[31:0];
    sz1_r    <= big_nxt ? sz_nxt[32:1] : sz_nxt[31:0];
    reach1_r <= big_nxt ? reach_nxt[32:1] : reach_nxt[31:0];
    ry1_r    <= ry_nxt;
    sy1_r    <= sy_nxt;
    sr1_r    <= in_item.sphere_radius;
    ch1_r    <= in_item.cyl_height;
  end

  // stage 2: products and vertical band
  logic signed [63:0] p_sxsx_r, p_szsz_r, p_rxsx_r, p_rzsz_r, p_rxrx_r, p_rzrz_r, p_rr_r;
  logic signed [35:0] lo_nxt, up_nxt;
  scc_pkg::vert_t     vert_nxt;
  scc_pkg::vert_t     vert2_r, vert3_r, vert4_r, vert5_r, vert6_r, vert7_r;

  always_comb begin
    lo_nxt = -{{4{sr1_r[31]}}, sr1_r} - {{3{ry1_r[32]}}, ry1_r};
    up_nxt = {{4{ch1_r[31]}}, ch1_r} + {{4{sr1_r[31]}}, sr1_r} - {{3{ry1_r[32]}}, ry1_r};
    vert_nxt.lim  = (sy1_r != '0);
    vert_nxt.miss = (sy1_r == '0) && ((lo_nxt > 36'sd0) || (up_nxt < 36'sd0));
    vert_nxt.lo_n = sy1_r[32] ? -lo_nxt : lo_nxt;
    vert_nxt.up_n = sy1_r[32] ? -up_nxt : up_nxt;
    vert_nxt.den  = sy1_r[32] ? 33'(-sy1_r) : 33'(sy1_r);
  end

  always_ff @(posedge clk) begin
    p_sxsx_r <= sx1_r * sx1_r;
    p_szsz_r <= sz1_r * sz1_r;
    p_rxsx_r <= rx1_r * sx1_r;
    p_rzsz_r <= rz1_r * sz1_r;
    p_rxrx_r <= rx1_r * rx1_r;
    p_rzrz_r <= rz1_r * rz1_r;
    p_rr_r   <= reach1_r * reach1_r;
    vert2_r  <= vert_nxt;
  end

  // stage 3: a, b, s
  logic [63:0]        a3_r, s3_r, r2_3_r;
  logic signed [64:0] b3_r;

  always_ff @(posedge clk) begin
    a3_r    <= p_sxsx_r + p_szsz_r;
    s3_r    <= p_rxrx_r + p_rzrz_r;
    r2_3_r  <= p_rr_r;
    b3_r    <= {p_rxsx_r[63], p_rxsx_r} + {p_rzsz_r[63], p_rzsz_r};
    vert3_r <= vert2_r;
  end

  // stage 4: c and magnitudes
  logic signed [64:0] c_nxt;
  scc_pkg::horz_t     h4_r, h5_r, h6_r;
  logic               cneg4_r, cneg5_r, cneg6_r;
  logic [63:0]        cmag4_r;

  assign c_nxt = {1'b0, s3_r} - {1'b0, r2_3_r};

  always_ff @(posedge clk) begin
    h4_r.a    <= a3_r;
    h4_r.bneg <= b3_r[64];
    h4_r.bmag <= b3_r[64] ? 64'(-b3_r) : b3_r[63:0];
    h4_r.lim  <= (a3_r != '0);
    // flat horizontal step that starts outside the reach
    h4_r.miss <= (a3_r == '0) && !c_nxt[64] && (c_nxt != '0);
    cneg4_r   <= c_nxt[64];
    cmag4_r   <= c_nxt[64] ? 64'(-c_nxt) : c_nxt[63:0];
    vert4_r   <= vert3_r;
  end

  // stage 5: 32x32 partial products of b*b and a*|c|
  logic [63:0] bb00_r, bb01_r, bb11_r, ac00_r, ac01_r, ac10_r, ac11_r;

  always_ff @(posedge clk) begin
    bb00_r  <= h4_r.bmag[31:0] * h4_r.bmag[31:0];
    bb01_r  <= h4_r.bmag[31:0] * h4_r.bmag[63:32];
    bb11_r  <= h4_r.bmag[63:32] * h4_r.bmag[63:32];
    ac00_r  <= h4_r.a[31:0] * cmag4_r[31:0];
    ac01_r  <= h4_r.a[31:0] * cmag4_r[63:32];
    ac10_r  <= h4_r.a[63:32] * cmag4_r[31:0];
    ac11_r  <= h4_r.a[63:32] * cmag4_r[63:32];
    h5_r    <= h4_r;
    cneg5_r <= cneg4_r;
    vert5_r <= vert4_r;
  end

  // stage 6: sum partials
  logic [127:0] bb6_r, ac6_r;

  always_ff @(posedge clk) begin
    bb6_r   <= {bb11_r, 64'd0} + {31'd0, bb01_r, 33'd0} + {64'd0, bb00_r};
    ac6_r   <= {ac11_r, 64'd0} + {32'd0, ac01_r, 32'd0} + {32'd0, ac10_r, 32'd0}
             + {64'd0, ac00_r};
    h6_r    <= h5_r;
    cneg6_r <= cneg5_r;
    vert6_r <= vert5_r;
  end

  // stage 7: discriminant b*b - a*c
  logic [129:0]   dsum_nxt;
  logic [127:0]   disc7_r;
  scc_pkg::horz_t h7_nxt;
  scc_pkg::horz_t h7_r;

  assign dsum_nxt = cneg6_r ? ({2'b00, bb6_r} + {2'b00, ac6_r})
                            : ({2'b00, bb6_r} - {2'b00, ac6_r});

  // drop the item on a negative discriminant
  always_comb begin
    h7_nxt      = h6_r;
    h7_nxt.miss = h6_r.miss || (h6_r.lim && dsum_nxt[129]);
  end

  always_ff @(posedge clk) begin
    disc7_r <= dsum_nxt[129] ? 128'd0 : dsum_nxt[127:0];
    h7_r    <= h7_nxt;
    vert7_r <= vert6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
    end
  end

  assign out_vld = vld7_r;
  assign disc    = disc7_r;
  assign side.h  = h7_r;
  assign side.v  = vert7_r;

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int PIPE_DEPTH = 93;
  localparam int IDLE_LIMIT = 4000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  scc_pkg::scc_in_t  in_item = '0;
  logic              out_valid;
  scc_pkg::scc_out_t out_item;

  // Expected contacts, oldest first.
  scc_pkg::scc_out_t contact_q[$];
  int       err_count = 0;
  int       idle_cycles = 0;
  // Percent chance that the sender skips a cycle; zero gives a back-to-back burst.
  int       gap_pct = 14;

  always #5 clk = ~clk;

  segment_cylinder_contact u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  // ---------------------------------------------------------------------------
  // Contact predictor: 128-bit integer arithmetic covers every intermediate.
  // ---------------------------------------------------------------------------

  // floor(num*65536/den) clamped to -1..65537; den > 0.
  function automatic longint frac_q16(logic signed [127:0] num, logic [127:0] den);
    logic signed [127:0] q;
    if (num == 0) return 0;
    if (num < 0) return -1;
    q = (num <<< 16) / $signed(den);
    if (q > 65537) return 65537;
    return longint'(q);
  endfunction

  // floor(sqrt(v)) for v below 2^128, bit by bit.
  function automatic logic [127:0] floor_root(logic [127:0] v);
    logic [127:0] r, c;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      c = r | (128'd1 << k);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [127:0] half_down(logic signed [127:0] v);
    return v >>> 1;
  endfunction

  function automatic bit fits_word(logic signed [127:0] v);
    return v >= -128'sd2147483648 && v <= 128'sd2147483647;
  endfunction

  function automatic scc_pkg::scc_out_t predict_contact(scc_pkg::scc_in_t q);
    logic signed [127:0] rx, ry, rz, sx, sy, sz, sr, ch, reach;
    logic signed [127:0] av, bv, cv, disc, root, lo_n, up_n;
    longint enter, leave, te, tl, t1, t2;
    bit miss;
    scc_pkg::scc_out_t r;
    rx = 128'(q.start_x) - 128'(q.base_x);
    ry = 128'(q.start_y) - 128'(q.base_y);
    rz = 128'(q.start_z) - 128'(q.base_z);
    sx = 128'(q.end_x) - 128'(q.start_x);
    sy = 128'(q.end_y) - 128'(q.start_y);
    sz = 128'(q.end_z) - 128'(q.start_z);
    sr = 128'(q.sphere_radius);
    ch = 128'(q.cyl_height);
    reach = (sr > 0 ? sr : 0) + (q.cyl_radius > 0 ? 128'(q.cyl_radius) : 0);
    enter = 0;
    leave = 65536;
    miss = 0;
    // Halve the horizontal terms together when any leaves 32 bits.
    if (!fits_word(rx) || !fits_word(rz) || !fits_word(sx) || !fits_word(sz) ||
        !fits_word(reach)) begin
      rx = half_down(rx); rz = half_down(rz);
      sx = half_down(sx); sz = half_down(sz);
      reach = half_down(reach);
    end
    av = sx * sx + sz * sz;
    bv = rx * sx + rz * sz;
    cv = rx * rx + rz * rz - reach * reach;
    if (av > 0) begin
      disc = bv * bv - av * cv;
      if (disc < 0) begin
        miss = 1;
      end else begin
        root = $signed(floor_root(disc));
        te = frac_q16(-bv - root, av);
        tl = frac_q16(-bv + root, av);
        if (te > enter) enter = te;
        if (tl < leave) leave = tl;
      end
    end else if (cv > 0) begin
      miss = 1;
    end
    if (!miss) begin
      lo_n = -sr - ry;
      up_n = ch + sr - ry;
      if (sy != 0) begin
        if (sy < 0) begin
          lo_n = -lo_n; up_n = -up_n; sy = -sy;
        end
        t1 = frac_q16(lo_n, sy);
        t2 = frac_q16(up_n, sy);
        if ((t1 < t2 ? t1 : t2) > enter) enter = t1 < t2 ? t1 : t2;
        if ((t1 < t2 ? t2 : t1) < leave) leave = t1 < t2 ? t2 : t1;
      end else if (ry < -sr || ry > ch + sr) begin
        miss = 1;
      end
    end
    r = '0;
    if (!miss && enter <= leave) begin
      r.hit = 1'b1;
      r.entry_time = 17'(enter);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared sender and result checker
  // ---------------------------------------------------------------------------

  // Offer one item, idle at random first, and hold it until accepted.
  // Call at a rising edge; returns at the accepting edge with start still high.
  task automatic send_query(scc_pkg::scc_in_t q);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= q;
    do @(posedge clk); while (busy);
    contact_q.push_back(predict_contact(q));
  endtask

  // Sample after the edge settles so nothing hinges on event order.
  always @(posedge clk) begin
    if (rst_n) begin
      #1;
      if (out_valid) begin
        if (contact_q.size() == 0) begin
          $display("%0t: result with nothing expected: hit=%0b t=%0d", $time,
                   out_item.hit, out_item.entry_time);
          err_count++;
        end else begin
          scc_pkg::scc_out_t exp_r;
          exp_r = contact_q.pop_front();
          if (out_item.hit !== exp_r.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, out_item.hit);
            err_count++;
          end
          if (out_item.entry_time !== exp_r.entry_time) begin
            $display("%0t: entry_time expected %0d actual %0d", $time,
                     exp_r.entry_time, out_item.entry_time);
            err_count++;
          end
        end
      end
    end
  end

  // Count cycles with no accepted item or result; stop a hung run.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("segment_cylinder_contact: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'($urandom);
      default: return $signed(32'($urandom_range(20 << 16))) - (10 << 16);
    endcase
  endfunction

  // Build a query with a scene scaled to 'span' Q16.16 units around the cylinder.
  function automatic scc_pkg::scc_in_t scene(int span);
    scc_pkg::scc_in_t q;
    q.base_x = $signed(32'($urandom_range(span << 1))) - span;
    q.base_y = $signed(32'($urandom_range(span << 1))) - span;
    q.base_z = $signed(32'($urandom_range(span << 1))) - span;
    q.start_x = q.base_x + $signed(32'($urandom_range(span << 1))) - span;
    q.start_y = q.base_y + $signed(32'($urandom_range(span << 1))) - span;
    q.start_z = q.base_z + $signed(32'($urandom_range(span << 1))) - span;
    q.end_x = q.base_x + $signed(32'($urandom_range(span << 1))) - span;
    q.end_y = $urandom_range(7) == 0 ? q.start_y
                                    : q.base_y + $signed(32'($urandom_range(span << 1))) - span;
    q.end_z = q.base_z + $signed(32'($urandom_range(span << 1))) - span;
    q.sphere_radius = $signed(32'($urandom_range(span >> 2))) - (span >> 4);
    q.cyl_radius = $signed(32'($urandom_range(span >> 1))) - (span >> 4);
    q.cyl_height = $signed(32'($urandom_range(span))) - (span >> 4);
    if ($urandom_range(9) == 0) begin
      q.end_x = q.start_x;
      q.end_z = q.start_z;
    end
    return q;
  endfunction

  // Hold the sender until every outstanding result is back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (contact_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    scc_pkg::scc_in_t q;
    // Straight pass through the axis of a unit cylinder.
    q = '0;
    q.start_x = -(4 << 16); q.end_x = 4 << 16;
    q.start_y = 1 << 16; q.end_y = 1 << 16;
    q.cyl_radius = 1 << 16; q.cyl_height = 2 << 16; q.sphere_radius = 1 << 15;
    send_query(q);
    // Same path but passing wide: negative discriminant.
    q.start_z = 5 << 16; q.end_z = 5 << 16;
    send_query(q);
    // No horizontal step, start inside the reach.
    q = '0;
    q.start_y = -(3 << 16); q.end_y = 3 << 16;
    q.cyl_radius = 1 << 16; q.cyl_height = 1 << 16;
    send_query(q);
    // No horizontal step, start outside the reach.
    q.start_x = 3 << 16; q.end_x = 3 << 16;
    send_query(q);
    // Flat vertical step above the band.
    q = '0;
    q.start_x = -(4 << 16); q.end_x = 4 << 16;
    q.start_y = 9 << 16; q.end_y = 9 << 16;
    q.cyl_radius = 1 << 16; q.cyl_height = 2 << 16;
    send_query(q);
    // Flat step below the band, then inside it.
    q.start_y = -(1 << 16); q.end_y = -(1 << 16);
    send_query(q);
    q.start_y = 1 << 16; q.end_y = 1 << 16;
    send_query(q);
    // Negative radii: reach clamps, band uses the raw sphere radius.
    q.sphere_radius = -(1 << 16); q.cyl_radius = -(1 << 16);
    send_query(q);
    // Descending step through the band.
    q = '0;
    q.start_y = 5 << 16; q.end_y = -(5 << 16);
    q.cyl_radius = 1 << 16; q.cyl_height = 1 << 16;
    send_query(q);
    // Field extremes that force the horizontal prescale.
    q = '0;
    q.start_x = 32'sh7fff_ffff; q.end_x = 32'sh8000_0000;
    q.start_z = 32'sh8000_0000; q.end_z = 32'sh7fff_ffff;
    q.base_x = 32'sh8000_0000;
    q.sphere_radius = 32'sh7fff_ffff; q.cyl_radius = 32'sh7fff_ffff;
    q.cyl_height = 32'sh7fff_ffff; q.end_y = 32'sh7fff_ffff;
    send_query(q);
    q = '1;
    send_query(q);
    q = '0;
    send_query(q);
    for (int i = 0; i < 12; i++) begin
      for (int f = 0; f < 12; f++) q[f*32 +: 32] = rand_word();
      send_query(q);
    end
  endtask

  // Scaled scenes of random content, with a slice of raw noise.
  task automatic test_random_scenes(int count);
    scc_pkg::scc_in_t q;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 2) begin
        for (int f = 0; f < 12; f++) q[f*32 +: 32] = rand_word();
      end else begin
        q = scene($urandom_range(3) == 0 ? (1 << 28) : (8 << 16));
      end
      send_query(q);
    end
  endtask

  // Back-to-back burst with no gaps, then a pause until all results are in.
  task automatic test_burst();
    gap_pct = 0;
    test_random_scenes(150);
    gap_pct = 14;
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_scenes(250);
    test_burst();
    test_random_scenes(300);
    drain_results();
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (err_count == 0) begin
      $display("segment_cylinder_contact: match");
    end else begin
      $display("segment_cylinder_contact: mismatch");
    end
    $finish;
  end
endmodule
